/* hdl/awd_pkg.sv */
// awd_pkg: types, codes and defaults shared by the readout word deframer
// no dependencies; imported by awd_parse and the core
package awd_pkg;

    // default sizes of the readout geometry
    localparam int AWD_MAX_MODULES         = 4;
    localparam int AWD_CHANNELS_PER_MODULE = 48;
    localparam int AWD_TRAILER_WORDS       = 10;

    // configuration register indexes
    localparam logic CFG_PACKET_LENGTH       = 1'b0;
    localparam logic CFG_SAMPLES_PER_CHANNEL = 1'b1;

    // samples_per_channel bounds and reset value
    localparam logic [5:0] SPC_MIN   = 6'd2;
    localparam logic [5:0] SPC_MAX   = 6'd32;
    localparam logic [5:0] SPC_RESET = 6'd24;

    // word tags
    localparam logic [3:0] TAG_HEADER  = 4'hF;
    localparam logic [3:0] TAG_CHANNEL = 4'hE;
    localparam logic [1:0] TAG_SAMPLE  = 2'b01;
    localparam logic [2:0] TAG_PARITY  = 3'b101;

    typedef enum logic [2:0] {
        KIND_SAMPLE     = 3'd0,
        KIND_HEADER     = 3'd1,
        KIND_BAD_MODULE = 3'd2,
        KIND_PARITY     = 3'd3,
        KIND_FORMAT_ERR = 3'd4,
        KIND_RANGE      = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_TRIG      = 3'd1,
        PH_BCLK      = 3'd2,
        PH_MODID     = 3'd3,
        PH_AFTER_HDR = 3'd4,
        PH_CHANNEL   = 3'd5,
        PH_DONE      = 3'd6
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] word_pos;
        logic [3:0]  cur_mod;
        logic [5:0]  cur_chan;
        logic [5:0]  samp_cnt;
        logic [11:0] trig;
        logic [11:0] bclk;
        logic [3:0]  hdrs;
    } t_state;

    localparam t_state STATE_CLEAR = '{
        phase:    PH_HEADER,
        word_pos: 16'd0,
        cur_mod:  4'd0,
        cur_chan: 6'd0,
        samp_cnt: 6'd0,
        trig:     12'd0,
        bclk:     12'd0,
        hdrs:     4'd0
    };

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  module_number;
        logic [5:0]  channel_number;
        logic [4:0]  sample_position;
        logic [11:0] sample_low;
        logic [11:0] sample_high;
        logic [11:0] trigger_number;
        logic [11:0] crossing_count;
        logic [4:0]  module_id;
        logic [11:0] parity_value;
        logic [3:0]  module_count;
        logic        packet_end;
    } t_result;

endpackage

/* hdl/awd_in_if.sv */
// awd_in_if: request channel carrying packet words into the deframer
// no dependencies
interface awd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic        first_word;

    modport source (output valid, data_word, first_word, input ready);
    modport sink (input valid, data_word, first_word, output ready);
endinterface

/* hdl/awd_out_if.sv */
// awd_out_if: result channel of the deframer, at most one decoded record per request
// no dependencies
interface awd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  module_number;
    logic [5:0]  channel_number;
    logic [4:0]  sample_position;
    logic [11:0] sample_low;
    logic [11:0] sample_high;
    logic [11:0] trigger_number;
    logic [11:0] crossing_count;
    logic [4:0]  module_id;
    logic [11:0] parity_value;
    logic [3:0]  module_count;
    logic        packet_end;

    modport source (output valid, kind, module_number, channel_number, sample_position,
                    sample_low, sample_high, trigger_number, crossing_count, module_id,
                    parity_value, module_count, packet_end, input ready);
    modport sink (input valid, kind, module_number, channel_number, sample_position,
                  sample_low, sample_high, trigger_number, crossing_count, module_id,
                  parity_value, module_count, packet_end, output ready);
endinterface

/* hdl/awd_parse.sv */
// awd_parse: word decoder, next parse state and result record for one word
// depends on awd_pkg
module awd_parse import awd_pkg::*; #(
    parameter int MAX_MODULES         = AWD_MAX_MODULES,
    parameter int CHANNELS_PER_MODULE = AWD_CHANNELS_PER_MODULE,
    parameter int TRAILER_WORDS       = AWD_TRAILER_WORDS
) (
    input  logic [31:0] i_word,
    input  logic        i_first,
    input  logic [15:0] i_pkt_len,
    input  logic [5:0]  i_spc,
    input  t_state      i_state,
    output t_state      o_state,
    output logic        o_res_valid,
    output t_result     o_res
);

    localparam logic [4:0]  MOD_LIMIT  = 5'(MAX_MODULES);
    localparam logic [6:0]  CHAN_LIMIT = 7'(CHANNELS_PER_MODULE);
    localparam logic [16:0] TRL_WORDS  = 17'(TRAILER_WORDS);

    t_state      st;
    logic        last;
    logic        before_trailer;
    logic        mod_ok;
    logic        chan_ok;
    logic [5:0]  pos;

    assign st             = i_first ? STATE_CLEAR : i_state;
    assign last           = (17'(st.word_pos) + 17'd1) == 17'(i_pkt_len);
    assign before_trailer = (17'(st.word_pos) + TRL_WORDS) < 17'(i_pkt_len);
    assign mod_ok         = {1'b0, st.cur_mod} < MOD_LIMIT;
    assign chan_ok        = {1'b0, st.cur_chan} < CHAN_LIMIT;
    assign pos            = st.samp_cnt;

    always_comb begin
        o_state     = st;
        o_res_valid = 1'b0;
        o_res       = '{
            kind:            KIND_SAMPLE,
            module_number:   st.cur_mod,
            channel_number:  st.cur_chan,
            sample_position: 5'd0,
            sample_low:      12'd0,
            sample_high:     12'd0,
            trigger_number:  st.trig,
            crossing_count:  st.bclk,
            module_id:       5'd0,
            parity_value:    12'd0,
            module_count:    st.hdrs,
            packet_end:      last
        };

        if (st.phase != PH_DONE) begin
            if (st.word_pos != 16'hFFFF) begin
                o_state.word_pos = st.word_pos + 16'd1;
            end
            if (st.word_pos >= i_pkt_len) begin
                // word beyond the packet length
                o_state.phase = PH_DONE;
            end else begin
                case (st.phase)
                    PH_TRIG: begin
                        o_state.trig  = i_word[11:0];
                        o_state.phase = PH_BCLK;
                    end
                    PH_BCLK: begin
                        o_state.bclk  = i_word[11:0];
                        o_state.phase = PH_MODID;
                    end
                    PH_MODID: begin
                        o_res_valid     = 1'b1;
                        o_res.kind      = mod_ok ? KIND_HEADER : KIND_BAD_MODULE;
                        o_res.module_id = i_word[4:0];
                        o_state.phase   = PH_AFTER_HDR;
                    end
                    default: begin
                        if (i_word[31:28] == TAG_CHANNEL &&
                            (st.phase == PH_AFTER_HDR || st.phase == PH_CHANNEL)) begin
                            o_state.cur_chan = i_word[21:16];
                            o_state.samp_cnt = 6'd0;
                            o_state.phase    = PH_CHANNEL;
                        end else if (i_word[31:30] == TAG_SAMPLE && st.phase == PH_CHANNEL) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = (mod_ok && chan_ok && (pos + 6'd1 < i_spc)) ?
                                          KIND_SAMPLE : KIND_RANGE;
                            o_res.sample_position = pos[5] ? 5'd31 : pos[4:0];
                            o_res.sample_low      = i_word[11:0];
                            o_res.sample_high     = i_word[27:16];
                            o_state.samp_cnt      = (pos >= 6'd30) ? SPC_MAX : pos + 6'd2;
                        end else if (before_trailer) begin
                            if (i_word[31:28] == TAG_HEADER) begin
                                if (st.hdrs != 4'hF) begin
                                    o_state.hdrs = st.hdrs + 4'd1;
                                end
                                o_state.cur_mod = i_word[3:0];
                                o_state.phase   = PH_TRIG;
                            end else begin
                                o_res_valid      = 1'b1;
                                o_res.kind       = KIND_FORMAT_ERR;
                                o_res.packet_end = 1'b1;
                                o_state.phase    = PH_DONE;
                            end
                        end else begin
                            // trailer region: parity word or silent end
                            if (i_word[31:29] == TAG_PARITY) begin
                                o_res_valid        = 1'b1;
                                o_res.kind         = KIND_PARITY;
                                o_res.parity_value = i_word[11:0];
                                o_res.packet_end   = 1'b1;
                            end
                            o_state.phase = PH_DONE;
                        end
                    end
                endcase
                if (last) begin
                    o_state.phase = PH_DONE;
                end
            end
        end
    end

endmodule

/* hdl/adc_readout_word_deframer_core.sv */
// adc readout word deframer core: depends on awd_pkg, awd_in_if, awd_out_if, awd_parse
// structure: a request is taken into the input register, decoded from there and its
//   record loads the output register
// throughput: one word per cycle while the receiver takes records; the only loop is the parse state register
// reset: synchronous active-low i_rst_n clears parse state, configuration
//   (packet_length 0, samples_per_channel 24) and both valid flags
module adc_readout_word_deframer_core import awd_pkg::*; #(
    parameter int MAX_MODULES         = AWD_MAX_MODULES,
    parameter int CHANNELS_PER_MODULE = AWD_CHANNELS_PER_MODULE,
    parameter int TRAILER_WORDS       = AWD_TRAILER_WORDS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_wdata,
    awd_in_if.sink       i_in,
    awd_out_if.source    o_out
);

    // configuration registers
    logic [15:0] r_pkt_len;
    logic [5:0]  r_spc;        // held already clamped to 2..32
    logic [5:0]  n_spc;

    // input register
    logic        r_in_valid;
    logic [31:0] r_in_word;
    logic        r_in_first;

    // parse state and output register
    t_state      r_state;
    t_state      n_state;
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;
    logic        n_res_valid;

    // the input stage moves on whenever the output register is free or being drained
    logic        advance;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;

    // clamp samples_per_channel at write time
    always_comb begin
        if (i_cfg_wdata[5:0] < SPC_MIN) begin
            n_spc = SPC_MIN;
        end else if (i_cfg_wdata[5:0] > SPC_MAX) begin
            n_spc = SPC_MAX;
        end else begin
            n_spc = i_cfg_wdata[5:0];
        end
    end

    awd_parse #(
        .MAX_MODULES         (MAX_MODULES),
        .CHANNELS_PER_MODULE (CHANNELS_PER_MODULE),
        .TRAILER_WORDS       (TRAILER_WORDS)
    ) u_parse (
        .i_word      (r_in_word),
        .i_first     (r_in_first),
        .i_pkt_len   (r_pkt_len),
        .i_spc       (r_spc),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_res_valid (n_res_valid),
        .o_res       (n_out)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_len <= 16'd0;
            r_spc     <= SPC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PACKET_LENGTH:       r_pkt_len <= i_cfg_wdata;
                CFG_SAMPLES_PER_CHANNEL: r_spc     <= n_spc;
                default:                 r_pkt_len <= r_pkt_len;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_word  <= i_in.data_word;
            r_in_first <= i_in.first_word;
        end
    end

    // parse state follows each word as it leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    // output register; words that give no record just drop out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && n_res_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_out.kind;
    assign o_out.module_number   = r_out.module_number;
    assign o_out.channel_number  = r_out.channel_number;
    assign o_out.sample_position = r_out.sample_position;
    assign o_out.sample_low      = r_out.sample_low;
    assign o_out.sample_high     = r_out.sample_high;
    assign o_out.trigger_number  = r_out.trigger_number;
    assign o_out.crossing_count  = r_out.crossing_count;
    assign o_out.module_id       = r_out.module_id;
    assign o_out.parity_value    = r_out.parity_value;
    assign o_out.module_count    = r_out.module_count;
    assign o_out.packet_end      = r_out.packet_end;

`ifndef NO_ASSERTIONS
    // terminating records always close the packet
    a_end_on_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == KIND_FORMAT_ERR || r_out.kind == KIND_PARITY)
        |-> r_out.packet_end)
        else $error("parity or format error record without packet end");

    // sample counter saturates at the largest channel depth
    a_samp_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.samp_cnt <= SPC_MAX)
        else $error("sample counter past saturation");

    // only sample and range records carry sample data
    a_sample_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind != KIND_SAMPLE && r_out.kind != KIND_RANGE
        |-> r_out.sample_low == 12'd0 && r_out.sample_high == 12'd0 &&
            r_out.sample_position == 5'd0)
        else $error("sample fields set on a non-sample record");

    // a good header record names an in-range module
    a_header_module: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_HEADER
        |-> {1'b0, r_out.module_number} < 5'(MAX_MODULES))
        else $error("header record with out-of-range module");
`endif

endmodule

/* test/adc_readout_word_deframer_core_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for adc_readout_word_deframer_core: directed table, then random packets
// depends on awd_pkg, awd_in_if, awd_out_if and the core; predicts every record in-line
module adc_readout_word_deframer_core_tb;
    import awd_pkg::*;

    localparam int IDLE_LIMIT   = 4000;  // cycles with no request moving on either side
    localparam int HOLD_CYCLES  = 400;   // one long receiver hold-off
    localparam int DRAIN_CYCLES = 4;     // two-stage pipeline plus margin
    localparam int RANDOM_WORDS = 1250;
    localparam int MAX_REPORTS  = 40;

    typedef enum logic {ROW_REG, ROW_WORD} t_row_op;

    typedef struct {
        t_row_op     op;
        logic        idx;
        logic [15:0] val;
        logic [31:0] word;
        logic        first;
        bit          typed;
        t_result     rec;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_wdata;

    awd_in_if  word_if();
    awd_out_if rec_if();

    adc_readout_word_deframer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (word_if),
        .o_out       (rec_if)
    );

    // predicted parse state and register copies
    t_phase      pk_phase;
    logic [15:0] pk_pos;
    logic [3:0]  pk_module;
    logic [5:0]  pk_channel;
    int          pk_samples;
    logic [11:0] pk_trig;
    logic [11:0] pk_bclk;
    logic [3:0]  pk_headers;
    logic [15:0] len_reg;
    logic [5:0]  spc_reg;

    t_result pending_records[$];
    t_row    script[$];
    int      sent_words;
    int      mismatches;
    int      burst_left;
    bit      regs_idle;
    bit      cfg_open;
    bit      long_hold_req;
    bit      long_hold_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result record(t_kind k, logic [3:0] mod, logic [5:0] chan,
                                       logic [4:0] pos, logic [11:0] lo, logic [11:0] hi,
                                       logic [11:0] trig, logic [11:0] bclk, logic [4:0] id,
                                       logic [11:0] par, logic [3:0] cnt, logic fin);
        t_result r;
        r.kind            = k;
        r.module_number   = mod;
        r.channel_number  = chan;
        r.sample_position = pos;
        r.sample_low      = lo;
        r.sample_high     = hi;
        r.trigger_number  = trig;
        r.crossing_count  = bclk;
        r.module_id       = id;
        r.parity_value    = par;
        r.module_count    = cnt;
        r.packet_end      = fin;
        return r;
    endfunction

    function automatic void clear_packet();
        pk_phase   = PH_HEADER;
        pk_pos     = '0;
        pk_module  = '0;
        pk_channel = '0;
        pk_samples = 0;
        pk_trig    = '0;
        pk_bclk    = '0;
        pk_headers = '0;
    endfunction

    // decode one accepted word; returns 1 when it makes a record
    function automatic bit deframe_word(input logic [31:0] w, input logic first,
                                        output t_result r);
        int p;
        int spc;
        int pos;
        bit last;
        bit hit;
        bit ok;
        hit = 1'b0;
        r = '0;
        if (first) clear_packet();
        // words after the end of a packet are dropped until the next first word
        if (pk_phase == PH_DONE) return 1'b0;
        p = pk_pos;
        if (pk_pos != 16'hffff) pk_pos++;
        // beyond the packet length: end with no record
        if (p >= int'(len_reg)) begin
            pk_phase = PH_DONE;
            return 1'b0;
        end
        last = (p + 1 == int'(len_reg));
        spc = spc_reg;
        if (spc < SPC_MIN) spc = SPC_MIN;
        if (spc > SPC_MAX) spc = SPC_MAX;

        case (pk_phase)
            PH_TRIG: begin
                pk_trig  = w[11:0];
                pk_phase = PH_BCLK;
            end
            PH_BCLK: begin
                pk_bclk  = w[11:0];
                pk_phase = PH_MODID;
            end
            PH_MODID: begin
                r = record((pk_module < AWD_MAX_MODULES) ? KIND_HEADER : KIND_BAD_MODULE,
                           pk_module, pk_channel, 0, 0, 0, pk_trig, pk_bclk, w[4:0], 0,
                           pk_headers, last);
                hit = 1'b1;
                pk_phase = PH_AFTER_HDR;
            end
            default: begin
                if (w[31:28] == TAG_CHANNEL &&
                    (pk_phase == PH_AFTER_HDR || pk_phase == PH_CHANNEL)) begin
                    pk_channel = w[21:16];
                    pk_samples = 0;
                    pk_phase   = PH_CHANNEL;
                end else if (w[31:30] == TAG_SAMPLE && pk_phase == PH_CHANNEL) begin
                    // bad module, bad channel or too many samples all give a range record
                    pos = pk_samples;
                    ok = pk_module < AWD_MAX_MODULES &&
                         pk_channel < AWD_CHANNELS_PER_MODULE && pos + 1 < spc;
                    r = record(ok ? KIND_SAMPLE : KIND_RANGE, pk_module, pk_channel,
                               (pos > 31) ? 31 : pos, w[11:0], w[27:16], pk_trig, pk_bclk,
                               0, 0, pk_headers, last);
                    hit = 1'b1;
                    pk_samples = (pos + 2 > 32) ? 32 : pos + 2;
                end else if (p + AWD_TRAILER_WORDS < int'(len_reg)) begin
                    if (w[31:28] == TAG_HEADER) begin
                        if (pk_headers != 4'hf) pk_headers++;
                        pk_module = w[3:0];
                        pk_phase  = PH_TRIG;
                    end else begin
                        // header expected but something else came
                        r = record(KIND_FORMAT_ERR, pk_module, pk_channel, 0, 0, 0, pk_trig,
                                   pk_bclk, 0, 0, pk_headers, 1'b1);
                        hit = 1'b1;
                        pk_phase = PH_DONE;
                    end
                end else begin
                    // trailer region: parity or a silent end
                    if (w[31:29] == TAG_PARITY) begin
                        r = record(KIND_PARITY, pk_module, pk_channel, 0, 0, 0, pk_trig,
                                   pk_bclk, 0, w[11:0], pk_headers, 1'b1);
                        hit = 1'b1;
                    end
                    pk_phase = PH_DONE;
                end
            end
        endcase

        if (last) pk_phase = PH_DONE;
        return hit;
    endfunction

    function automatic void add_reg(input logic idx, input logic [15:0] val);
        script.push_back('{ROW_REG, idx, val, 32'h0, 1'b0, 1'b0, t_result'('0)});
    endfunction

    function automatic void add_word(input logic [31:0] w, input logic first);
        script.push_back('{ROW_WORD, 1'b0, 16'h0, w, first, 1'b0, t_result'('0)});
    endfunction

    function automatic void add_checked(input logic [31:0] w, input logic first,
                                        input t_result want);
        script.push_back('{ROW_WORD, 1'b0, 16'h0, w, first, 1'b1, want});
    endfunction

    task automatic build_script();
        // zero packet length: the first word is already past the end
        add_word(32'hF000_0003, 1'b1);
        // non-header word where a header is due, then a word after the end
        add_reg(CFG_PACKET_LENGTH, 16'd20);
        add_checked(32'h0000_0000, 1'b1,
                    record(KIND_FORMAT_ERR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        add_word(32'hFFFF_FFFF, 1'b0);
        // full module with extreme samples, bad channel, too many samples, parity
        add_reg(CFG_PACKET_LENGTH, 16'd14);
        add_reg(CFG_SAMPLES_PER_CHANNEL, 16'd2);
        add_word(32'hF000_0002, 1'b1);
        add_word(32'hFFFF_FFFF, 1'b0);
        add_word(32'h0000_0ABC, 1'b0);
        add_checked(32'h0000_001F, 1'b0,
                    record(KIND_HEADER, 2, 0, 0, 0, 0, 12'hfff, 12'habc, 5'h1f, 0, 1, 1'b0));
        add_word(32'hE02F_0000, 1'b0);
        add_checked(32'h4FFF_0FFF, 1'b0,
                    record(KIND_SAMPLE, 2, 47, 0, 12'hfff, 12'hfff, 12'hfff, 12'habc, 0, 0, 1,
                           1'b0));
        add_word(32'h7123_0456, 1'b0);
        add_word(32'hE030_0000, 1'b0);
        add_word(32'h4000_0000, 1'b0);
        add_checked(32'hBFFF_FFFF, 1'b0,
                    record(KIND_PARITY, 2, 48, 0, 0, 0, 12'hfff, 12'habc, 0, 12'hfff, 1, 1'b1));
        // longest packet, sample count clamped high, bad module then sample after header
        add_reg(CFG_PACKET_LENGTH, 16'hFFFF);
        add_reg(CFG_SAMPLES_PER_CHANNEL, 16'hFFFF);
        add_word(32'hF000_000F, 1'b1);
        add_word(32'h0000_0000, 1'b0);
        add_word(32'h0000_0000, 1'b0);
        add_checked(32'h0000_0000, 1'b0,
                    record(KIND_BAD_MODULE, 15, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1'b0));
        add_checked(32'h4000_0001, 1'b0,
                    record(KIND_FORMAT_ERR, 15, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1'b1));
        // restart inside a header, sample pair on the last word of the packet
        add_reg(CFG_PACKET_LENGTH, 16'd7);
        add_reg(CFG_SAMPLES_PER_CHANNEL, 16'd4);
        add_word(32'hF000_0000, 1'b1);
        add_word(32'hF000_0003, 1'b1);
        add_word(32'h5555_5555, 1'b0);
        add_word(32'h0000_0000, 1'b0);
        add_word(32'h0000_0015, 1'b0);
        add_word(32'hE005_0000, 1'b0);
        add_word(32'h4001_0002, 1'b0);
        add_word(32'h4003_0004, 1'b0);
    endtask

    // let every outstanding record come out, then the pipeline empty
    task automatic drain_records();
        word_if.valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [15:0] val);
        if (!regs_idle) begin
            drain_records();
            regs_idle = 1'b1;
        end
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        cfg_open = 1'b1;
        if (idx == CFG_PACKET_LENGTH) len_reg = val;
        else spc_reg = val[5:0];
    endtask

    // offer one word as a request; bursts with random gaps between them
    task automatic push_word(input logic [31:0] w, input logic first, input bit typed,
                             input t_result want);
        t_result got;
        bit      hit;
        int      gap;
        if (cfg_open) begin
            i_cfg_we <= 1'b0;
            cfg_open = 1'b0;
        end
        regs_idle = 1'b0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                word_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        word_if.valid      <= 1'b1;
        word_if.data_word  <= w;
        word_if.first_word <= first;
        do @(posedge i_clk); while (word_if.ready !== 1'b1);
        sent_words++;
        hit = deframe_word(w, first, got);
        if (typed) pending_records.push_back(want);
        else if (hit) pending_records.push_back(got);
    endtask

    // one random packet: mostly well formed, some corrupted, truncated or pure noise
    task automatic random_packet(input bit hold_here);
        logic [31:0] pkt[$];
        logic        restart[$];
        logic [31:0] w;
        logic [15:0] spc_val;
        int          mode;
        int          nmod;
        int          nch;
        int          npair;
        int          last_hdr;
        int          lo;
        int          len;
        int          j;
        mode = hold_here ? 0 : $urandom_range(0, 9);
        nmod = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 18) : $urandom_range(1, 3);
        if (hold_here) nmod = 3;
        last_hdr = 0;
        if (mode == 9) begin
            repeat ($urandom_range(3, 12)) begin
                pkt.push_back($urandom);
                restart.push_back($urandom_range(0, 3) == 0);
            end
            len = $urandom_range(0, 24);
        end else begin
            repeat (nmod) begin
                last_hdr = pkt.size();
                w = $urandom;
                w[31:28] = TAG_HEADER;
                w[3:0] = ($urandom_range(0, 5) == 0) ? $urandom_range(AWD_MAX_MODULES, 15)
                                                     : $urandom_range(0, AWD_MAX_MODULES - 1);
                pkt.push_back(w);
                restart.push_back(1'b0);
                repeat (3) begin
                    pkt.push_back($urandom);
                    restart.push_back(1'b0);
                end
                nch = $urandom_range(0, 3);
                repeat (nch) begin
                    w = $urandom;
                    w[31:28] = TAG_CHANNEL;
                    w[21:16] = ($urandom_range(0, 7) == 0) ?
                               $urandom_range(AWD_CHANNELS_PER_MODULE, 63) :
                               $urandom_range(0, AWD_CHANNELS_PER_MODULE - 1);
                    pkt.push_back(w);
                    restart.push_back(1'b0);
                    npair = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 18)
                                                        : $urandom_range(0, 6);
                    repeat (npair) begin
                        w = $urandom;
                        w[31:30] = TAG_SAMPLE;
                        pkt.push_back(w);
                        restart.push_back(1'b0);
                    end
                end
            end
            w = $urandom;
            w[31:29] = TAG_PARITY;
            pkt.push_back(w);
            restart.push_back(1'b0);
            // parity inside the trailer, last header still before it
            lo = (last_hdr + 11 > pkt.size()) ? last_hdr + 11 : pkt.size();
            len = $urandom_range(lo, pkt.size() + 9);
            if (mode == 7) begin
                j = $urandom_range(1, pkt.size() - 1);
                if ($urandom_range(0, 1)) pkt[j] = $urandom;
                else restart[j] = 1'b1;
            end
            if (mode == 8) len = $urandom_range(0, pkt.size());
            repeat ($urandom_range(0, 2)) begin
                pkt.push_back($urandom);
                restart.push_back(1'b0);
            end
        end
        restart[0] = 1'b1;

        reg_write(CFG_PACKET_LENGTH, len);
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0:       spc_val = 16'd0;
                1:       spc_val = 16'd1;
                2:       spc_val = 16'd2;
                3:       spc_val = 16'd32;
                4:       spc_val = $urandom_range(0, 16'hffff);
                default: spc_val = $urandom_range(3, 31);
            endcase
            reg_write(CFG_SAMPLES_PER_CHANNEL, spc_val);
        end
        if (hold_here) long_hold_req = 1'b1;
        foreach (pkt[i]) push_word(pkt[i], restart[i], 1'b0, t_result'('0));
    endtask

    task automatic check_field(input string name, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // stimulus: reset, directed table, then random packets
    initial begin
        int pkt_no;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= 1'b0;
        i_cfg_wdata        <= '0;
        word_if.valid      <= 1'b0;
        word_if.data_word  <= '0;
        word_if.first_word <= 1'b0;
        clear_packet();
        len_reg        = '0;
        spc_reg        = SPC_RESET;
        sent_words     = 0;
        mismatches     = 0;
        burst_left     = 0;
        regs_idle      = 1'b1;
        cfg_open       = 1'b0;
        long_hold_req  = 1'b0;
        long_hold_done = 1'b0;
        build_script();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].op == ROW_REG) reg_write(script[i].idx, script[i].val);
            else push_word(script[i].word, script[i].first, script[i].typed, script[i].rec);
        end

        // random part stops once enough words have been sent
        sent_words = 0;
        pkt_no = 0;
        while (sent_words < RANDOM_WORDS) begin
            random_packet(pkt_no == 4);
            pkt_no++;
        end

        drain_records();
        if (mismatches == 0) begin
            $display("** adc_readout_word_deframer_core: PASSED **");
        end else begin
            $display("** adc_readout_word_deframer_core: FAILED **");
        end
        $finish;
    end

    // receiver: one long hold-off on request, otherwise changing stall patterns
    initial begin
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        rec_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !long_hold_done) begin
                rec_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 150);
                end
                left--;
                tick++;
                case (mode)
                    0:       rec_if.ready <= 1'b1;
                    1:       rec_if.ready <= $urandom_range(0, 1);
                    2:       rec_if.ready <= (tick % 3 != 0);
                    default: rec_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // compare each record with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rec_if.valid === 1'b1 && rec_if.ready === 1'b1) begin
            if (pending_records.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: record expected none got kind %0h", $time, rec_if.kind);
                mismatches++;
            end else begin
                want = pending_records.pop_front();
                check_field("kind", want.kind, rec_if.kind);
                check_field("module_number", want.module_number, rec_if.module_number);
                check_field("channel_number", want.channel_number, rec_if.channel_number);
                check_field("sample_position", want.sample_position, rec_if.sample_position);
                check_field("sample_low", want.sample_low, rec_if.sample_low);
                check_field("sample_high", want.sample_high, rec_if.sample_high);
                check_field("trigger_number", want.trigger_number, rec_if.trigger_number);
                check_field("crossing_count", want.crossing_count, rec_if.crossing_count);
                check_field("module_id", want.module_id, rec_if.module_id);
                check_field("parity_value", want.parity_value, rec_if.parity_value);
                check_field("module_count", want.module_count, rec_if.module_count);
                check_field("packet_end", want.packet_end, rec_if.packet_end);
            end
        end
    end

    // watchdog: too long with no request moving on either side
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n ||
            (word_if.valid === 1'b1 && word_if.ready === 1'b1) ||
            (rec_if.valid === 1'b1 && rec_if.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** adc_readout_word_deframer_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
